// ===== design/kpc_pkg.sv =====
package kpc_pkg;

  // Keypad key codes
  localparam logic [7:0] KeyA   = 8'h41;
  localparam logic [7:0] KeyEq  = 8'h3D;
  localparam logic [7:0] KeyAdd = 8'h2B;
  localparam logic [7:0] KeySub = 8'h2D;
  localparam logic [7:0] KeyMul = 8'h2A;
  localparam logic [7:0] KeyDiv = 8'h2F;
  localparam logic [7:0] Ascii0 = 8'd48;

  localparam int PcW     = 4;
  localparam int OpndW   = 13;
  localparam int MagW    = 12;
  localparam int ValW    = 14;
  localparam int ResW    = 16;
  localparam int DivBits = MagW;

  localparam logic [ResW-1:0] LimitPlain = 16'd1000;
  localparam logic [ResW-1:0] LimitMul   = 16'd10000;

  typedef logic [PcW-1:0]          pc_t;
  typedef logic signed [OpndW-1:0] opnd_t;
  typedef logic [MagW-1:0]         mag_t;
  typedef logic [ValW-1:0]         val_t;
  typedef logic [ResW-1:0]         res_t;

  typedef enum logic [3:0] {
    U_FETCH,
    U_JUMP,
    U_LOAD,
    U_ARITH,
    U_DIVSTEP,
    U_DIVFIX,
    U_RANGE,
    U_EMIT_EQ,
    U_DIGSTEP,
    U_EMIT_DIG,
    U_EMIT_UNIT,
    U_CLEAR,
    U_ECHO
  } uop_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_REJECT,
    C_POS_LT5,
    C_NOT_DIV,
    C_CNT_MORE,
    C_NOT_SHOW,
    C_PL_MORE
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Program entry points
  localparam pc_t PcFetch   = 4'd0;
  localparam pc_t PcDivStep = 4'd6;
  localparam pc_t PcRange   = 4'd8;
  localparam pc_t PcDigStep = 4'd11;
  localparam pc_t PcClear   = 4'd14;
  localparam pc_t PcEcho    = 4'd15;

  // Control store: one word per step
  function automatic ctrl_t rom(input pc_t pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{U_FETCH,     C_NEXT,     PcFetch};
      4'd1:    w = '{U_JUMP,      C_REJECT,   PcClear};
      4'd2:    w = '{U_JUMP,      C_POS_LT5,  PcEcho};
      4'd3:    w = '{U_LOAD,      C_NEXT,     PcFetch};
      4'd4:    w = '{U_ARITH,     C_NEXT,     PcFetch};
      4'd5:    w = '{U_JUMP,      C_NOT_DIV,  PcRange};
      4'd6:    w = '{U_DIVSTEP,   C_CNT_MORE, PcDivStep};
      4'd7:    w = '{U_DIVFIX,    C_NEXT,     PcFetch};
      4'd8:    w = '{U_RANGE,     C_NEXT,     PcFetch};
      4'd9:    w = '{U_EMIT_EQ,   C_NEXT,     PcFetch};
      4'd10:   w = '{U_JUMP,      C_NOT_SHOW, PcFetch};
      4'd11:   w = '{U_DIGSTEP,   C_CNT_MORE, PcDigStep};
      4'd12:   w = '{U_EMIT_DIG,  C_PL_MORE,  PcDigStep};
      4'd13:   w = '{U_EMIT_UNIT, C_ALWAYS,   PcFetch};
      4'd14:   w = '{U_CLEAR,     C_ALWAYS,   PcFetch};
      4'd15:   w = '{U_ECHO,      C_ALWAYS,   PcFetch};
      default: w = '{U_FETCH,     C_NEXT,     PcFetch};
    endcase
    return w;
  endfunction

  // Operand from two digit keys: 10*(hi-48) + (lo-48)
  function automatic opnd_t operand(input logic [7:0] hi, input logic [7:0] lo);
    logic signed [8:0] h;
    logic signed [8:0] l;
    opnd_t hx;
    opnd_t lx;
    h  = $signed({1'b0, hi}) - $signed({1'b0, Ascii0});
    l  = $signed({1'b0, lo}) - $signed({1'b0, Ascii0});
    hx = opnd_t'(h);
    lx = opnd_t'(l);
    return (hx <<< 3) + (hx <<< 1) + lx;
  endfunction

  function automatic val_t place_weight(input logic [1:0] pl);
    val_t w;
    case (pl)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      default: w = 14'd10;
    endcase
    return w;
  endfunction

  function automatic val_t place_limit(input logic [1:0] pl);
    val_t w;
    case (pl)
      2'd0:    w = 14'd10000;
      2'd1:    w = 14'd1000;
      default: w = 14'd100;
    endcase
    return w;
  endfunction

endpackage

// ===== design/kpc_key_if.sv =====
interface kpc_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

// ===== design/kpc_res_if.sv =====
interface kpc_res_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] glyph;
  logic       last;

  modport source (output valid, output action, output glyph, output last, input ready);
  modport sink   (input valid, input action, input glyph, input last, output ready);
endinterface

// ===== design/keypad_two_digit_calculator_top.sv =====
// Two-digit keypad calculator.
// key_i carries one key code per word; res_o carries display words
// (action: 0 show glyph, 1 clear display; last marks the final word of a key).
// Entry runs digit, digit, operator, digit, digit, '='. Accepted keys are
// echoed, a rejected key gives a single clear word and restarts entry.
// On '=' the block echoes '=' and prints a valid in-range result in decimal.
// A small microcoded sequencer steps through a 16-word control store; the
// step counter advances one control word per cycle unless waiting for a key
// or for room in the output register.
// After the fetch step takes a key, the key check jumps to the clear step
// for a rejected key; otherwise the position check jumps to the echo step.
// The '=' word follows the load, arithmetic and range steps ('/' adds 12
// restoring divider steps and a sign fix); each decimal place then takes 4
// compare-subtract steps and an emit, and the units a final emit, after
// which the key side is free again (after the '=' word if no digits show).
// key_i.ready is high only in the fetch step, so one key is in flight at a
// time; results sit in a one-word output register.
// When res_o.ready is low the sequencer holds at its emit step; nothing is
// dropped. Reset clears the step counter, entry position and output valid;
// the stored keys are written before they are read.
module keypad_two_digit_calculator_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  kpc_key_if.sink          key_i,
  kpc_res_if.source        res_o
);

  localparam int OpndW = kpc_pkg::OpndW;

  // Sequencer and datapath registers
  kpc_pkg::pc_t   pc_q, pc_d;
  logic [2:0]     pos_q, pos_d;
  logic [7:0]     key_q, key_d;
  logic [7:0]     keys_q [5];
  kpc_pkg::opnd_t a_q, a_d, b_q, b_d;
  kpc_pkg::res_t  r_q, r_d;
  logic           valid_q, valid_d;
  logic           neg_q, neg_d;
  kpc_pkg::mag_t  bmag_q, bmag_d, quo_q, quo_d, rem_q, rem_d;
  logic [3:0]     cnt_q, cnt_d;
  logic           show_q, show_d;
  kpc_pkg::val_t  v_q, v_d;
  logic [3:0]     dig_q, dig_d;
  logic [1:0]     pl_q, pl_d;
  logic           started_q, started_d;
  logic           out_valid_q, out_valid_d;
  logic           out_action_q, out_action_d;
  logic [7:0]     out_glyph_q, out_glyph_d;
  logic           out_last_q, out_last_d;

  kpc_pkg::ctrl_t ctrl;
  logic           in_fire;
  logic           slot_free;
  logic           emit_want;
  logic           done;
  logic           cond_true;
  logic           reject;
  logic           write_key;
  logic [3:0]     cnt_last;
  logic           is_div;

  // Combinational arithmetic terms
  logic signed [OpndW:0]       sum_s, diff_s;
  logic signed [2*OpndW-1:0]   prod_s;
  kpc_pkg::mag_t               amag, bmag;
  logic [kpc_pkg::MagW:0]      rem_sh;
  kpc_pkg::val_t               weight;
  kpc_pkg::res_t               limit;

  assign ctrl      = kpc_pkg::rom(pc_q);
  assign key_i.ready = (ctrl.op == kpc_pkg::U_FETCH);
  assign in_fire   = key_i.valid && key_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;

  assign res_o.valid  = out_valid_q;
  assign res_o.action = out_action_q;
  assign res_o.glyph  = out_glyph_q;
  assign res_o.last   = out_last_q;

  assign is_div   = (keys_q[2] == kpc_pkg::KeyDiv);
  assign cnt_last = (ctrl.op == kpc_pkg::U_DIVSTEP) ? 4'(kpc_pkg::DivBits - 1) : 4'd3;
  assign limit    = (keys_q[2] == kpc_pkg::KeyMul) ? kpc_pkg::LimitMul : kpc_pkg::LimitPlain;

  // Key check: operator slot rejects only 'A' and '=', the final slot wants '='
  always_comb begin
    if (pos_q == 3'd2) begin
      reject = (key_q == kpc_pkg::KeyA) || (key_q == kpc_pkg::KeyEq);
    end else if (pos_q < 3'd5) begin
      reject = (key_q == kpc_pkg::KeyA)   || (key_q == kpc_pkg::KeyEq)  ||
               (key_q == kpc_pkg::KeyAdd) || (key_q == kpc_pkg::KeySub) ||
               (key_q == kpc_pkg::KeyMul) || (key_q == kpc_pkg::KeyDiv);
    end else begin
      reject = (key_q != kpc_pkg::KeyEq);
    end
  end

  assign sum_s  = (OpndW+1)'(a_q) + (OpndW+1)'(b_q);
  assign diff_s = (OpndW+1)'(a_q) - (OpndW+1)'(b_q);
  assign prod_s = a_q * b_q;
  assign amag   = kpc_pkg::mag_t'(a_q[OpndW-1] ? -a_q : a_q);
  assign bmag   = kpc_pkg::mag_t'(b_q[OpndW-1] ? -b_q : b_q);
  assign rem_sh = {rem_q, quo_q[kpc_pkg::MagW-1]};
  assign weight = kpc_pkg::val_t'(kpc_pkg::place_weight(pl_q) << (2'd3 - cnt_q[1:0]));

  // Emit request and step completion
  always_comb begin
    case (ctrl.op)
      kpc_pkg::U_EMIT_EQ,
      kpc_pkg::U_EMIT_UNIT,
      kpc_pkg::U_CLEAR,
      kpc_pkg::U_ECHO:     emit_want = 1'b1;
      kpc_pkg::U_EMIT_DIG: emit_want = started_q || (dig_q != 4'd0);
      default:             emit_want = 1'b0;
    endcase
    if (ctrl.op == kpc_pkg::U_FETCH) begin
      done = in_fire;
    end else begin
      done = !emit_want || slot_free;
    end
  end

  // Jump condition
  always_comb begin
    case (ctrl.cond)
      kpc_pkg::C_NEXT:     cond_true = 1'b0;
      kpc_pkg::C_ALWAYS:   cond_true = 1'b1;
      kpc_pkg::C_REJECT:   cond_true = reject;
      kpc_pkg::C_POS_LT5:  cond_true = (pos_q < 3'd5);
      kpc_pkg::C_NOT_DIV:  cond_true = !is_div;
      kpc_pkg::C_CNT_MORE: cond_true = (cnt_q != cnt_last);
      kpc_pkg::C_NOT_SHOW: cond_true = !show_q;
      kpc_pkg::C_PL_MORE:  cond_true = (pl_q != 2'd2);
      default:             cond_true = 1'b0;
    endcase
  end

  assign pc_d      = done ? (cond_true ? ctrl.target : pc_q + 4'd1) : pc_q;
  assign write_key = (ctrl.op == kpc_pkg::U_ECHO) && done;

  // Datapath under control of the current word
  always_comb begin
    pos_d        = pos_q;
    key_d        = key_q;
    a_d          = a_q;
    b_d          = b_q;
    r_d          = r_q;
    valid_d      = valid_q;
    neg_d        = neg_q;
    bmag_d       = bmag_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    show_d       = show_q;
    v_d          = v_q;
    dig_d        = dig_q;
    pl_d         = pl_q;
    started_d    = started_q;
    out_action_d = out_action_q;
    out_glyph_d  = out_glyph_q;
    out_last_d   = out_last_q;

    case (ctrl.op)
      kpc_pkg::U_FETCH: begin
        if (in_fire) begin
          key_d = key_i.key_code;
        end
      end
      kpc_pkg::U_LOAD: begin
        a_d   = kpc_pkg::operand(keys_q[0], keys_q[1]);
        b_d   = kpc_pkg::operand(keys_q[3], keys_q[4]);
        pos_d = 3'd0;
      end
      kpc_pkg::U_ARITH: begin
        cnt_d  = 4'd0;
        quo_d  = amag;
        rem_d  = '0;
        bmag_d = bmag;
        neg_d  = a_q[OpndW-1] ^ b_q[OpndW-1];
        case (keys_q[2])
          kpc_pkg::KeyAdd: begin
            r_d     = kpc_pkg::res_t'(sum_s);
            valid_d = 1'b1;
          end
          kpc_pkg::KeySub: begin
            r_d     = kpc_pkg::res_t'(diff_s);
            valid_d = 1'b1;
          end
          kpc_pkg::KeyMul: begin
            r_d     = prod_s[kpc_pkg::ResW-1:0];
            valid_d = 1'b1;
          end
          kpc_pkg::KeyDiv: begin
            r_d     = '0;
            valid_d = (b_q != '0);
          end
          default: begin
            r_d     = '0;
            valid_d = 1'b0;
          end
        endcase
      end
      kpc_pkg::U_DIVSTEP: begin
        // Restoring division on magnitudes, one quotient bit per step
        if (rem_sh >= {1'b0, bmag_q}) begin
          rem_d = kpc_pkg::mag_t'(rem_sh - {1'b0, bmag_q});
          quo_d = {quo_q[kpc_pkg::MagW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[kpc_pkg::MagW-1:0];
          quo_d = {quo_q[kpc_pkg::MagW-2:0], 1'b0};
        end
        cnt_d = (cnt_q == cnt_last) ? 4'd0 : cnt_q + 4'd1;
      end
      kpc_pkg::U_DIVFIX: begin
        r_d = neg_q ? (kpc_pkg::res_t'(0) - kpc_pkg::res_t'(quo_q)) : kpc_pkg::res_t'(quo_q);
      end
      kpc_pkg::U_RANGE: begin
        show_d    = valid_q && (r_q < limit);
        v_d       = r_q[kpc_pkg::ValW-1:0];
        pl_d      = 2'd0;
        cnt_d     = 4'd0;
        dig_d     = 4'd0;
        started_d = 1'b0;
      end
      kpc_pkg::U_EMIT_EQ: begin
        out_action_d = 1'b0;
        out_glyph_d  = kpc_pkg::KeyEq;
        out_last_d   = !show_q;
      end
      kpc_pkg::U_DIGSTEP: begin
        // Subtract 8, 4, 2, 1 times the place weight, MSB of the digit first
        if (v_q >= weight) begin
          v_d   = v_q - weight;
          dig_d = {dig_q[2:0], 1'b1};
        end else begin
          dig_d = {dig_q[2:0], 1'b0};
        end
        cnt_d = (cnt_q == cnt_last) ? 4'd0 : cnt_q + 4'd1;
      end
      kpc_pkg::U_EMIT_DIG: begin
        out_action_d = 1'b0;
        out_glyph_d  = kpc_pkg::Ascii0 + {4'd0, dig_q};
        out_last_d   = 1'b0;
        if (done) begin
          started_d = started_q || (dig_q != 4'd0);
          dig_d     = 4'd0;
          cnt_d     = 4'd0;
          pl_d      = pl_q + 2'd1;
        end
      end
      kpc_pkg::U_EMIT_UNIT: begin
        out_action_d = 1'b0;
        out_glyph_d  = kpc_pkg::Ascii0 + {4'd0, v_q[3:0]};
        out_last_d   = 1'b1;
      end
      kpc_pkg::U_CLEAR: begin
        out_action_d = 1'b1;
        out_glyph_d  = 8'd0;
        out_last_d   = 1'b1;
        if (done) begin
          pos_d = 3'd0;
        end
      end
      kpc_pkg::U_ECHO: begin
        out_action_d = 1'b0;
        out_glyph_d  = key_q;
        out_last_d   = 1'b1;
        if (done) begin
          pos_d = pos_q + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load on an emit, drop once taken
  always_comb begin
    if (emit_want && slot_free) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= kpc_pkg::PcFetch;
      pos_q       <= 3'd0;
      cnt_q       <= 4'd0;
      pl_q        <= 2'd0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      pl_q        <= pl_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    a_q     <= a_d;
    b_q     <= b_d;
    r_q     <= r_d;
    valid_q <= valid_d;
    neg_q   <= neg_d;
    bmag_q  <= bmag_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    show_q  <= show_d;
    v_q     <= v_d;
    dig_q   <= dig_d;
    if (emit_want && slot_free) begin
      out_action_q <= out_action_d;
      out_glyph_q  <= out_glyph_d;
      out_last_q   <= out_last_d;
    end
  end

  // Key store
  always_ff @(posedge clk_i) begin
    if (write_key) begin
      keys_q[pos_q] <= key_q;
    end
  end

  // Entry position stays within the six slots
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= 3'd5)
    else $error("entry position out of range");

  // A clear word is always the only word of its key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.action) |-> res_o.last)
    else $error("clear word without last");

  // Each decimal place starts with a remainder below ten times its weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == kpc_pkg::U_DIGSTEP && cnt_q == 4'd0) |-> (v_q < kpc_pkg::place_limit(pl_q)))
    else $error("decimal remainder exceeds place range");

  // A taken key always moves the sequencer on to its key check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pc_q == 4'd1))
    else $error("sequencer did not advance after key");

endmodule
